/* rtl/cba_pkg.sv */
package cba_pkg;

  localparam int IDX_W      = 16;
  localparam int CNT_W      = 17;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CNT_W-1:0] CLU_TOTAL_RESET = 17'd65536;

  localparam logic REQ_SET  = 1'b0;
  localparam logic REQ_FIND = 1'b1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_CLU_TOTAL      = 2'd0,
    CFG_ZONE_BASE      = 2'd1,
    CFG_PROTECT_SYSTEM = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic             req_type;
    logic [IDX_W-1:0] clu_index;
    logic             mark_used;
  } req_word_t;

  typedef struct packed {
    logic             refused;
    logic             free_found;
    logic [IDX_W-1:0] free_index;
  } rsp_word_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_SET_RD,
    ST_SET_CHK,
    ST_FIND,
    ST_DONE
  } seq_state_t;

endpackage

/* rtl/cba_word_if.sv */
interface cba_word_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* rtl/cluster_bitmap_allocator_top.sv */
// Cluster bitmap allocator. Keeps one used bit per cluster in a map memory of
// MAP_WORD_BITS-bit words and serves one request at a time on the req word
// channel, answering each with exactly one rsp word. A set request marks a
// cluster used or free and reports refused when the index is at or past the
// cluster count, lies below the data zone while protection is on, or already
// holds the asked value; it passes through the divider, a map read and a
// check-and-write, or goes straight to the result when the range or
// protection check refuses it at once. The map word and bit of an index come
// from a shift and a mask, so MAP_WORD_BITS must be a power of two. A find
// request scans the map one word per cycle from word 0 and returns the lowest
// free cluster below the cluster count; it stops at the word holding the
// lowest free bit, or after all ceil(cluster_count / MAP_WORD_BITS) words
// when none is free (no word at all for a zero count). A finished result waits
// until the output register can take it. After reset a clearing pass writes
// every map word to zero, during which req.ready stays low; config writes are
// taken at any time. Config is expected to change only while the block is
// idle. A result waits in the output register, so the next request is taken
// while it is still held.
module cluster_bitmap_allocator_top
  import cba_pkg::*;
#(
  parameter int MAX_CLUSTERS  = 65536,
  parameter int MAP_WORD_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  cba_word_if.sink              req,
  cba_word_if.source            rsp,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH = (MAX_CLUSTERS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = $clog2(DEPTH + 1);
  localparam int BW    = $clog2(DEPTH * MAP_WORD_BITS + MAP_WORD_BITS + 1);
  localparam int BIW   = $clog2(MAP_WORD_BITS);
  localparam int MW    = MAP_WORD_BITS;

  // config registers
  logic [CNT_W-1:0] clu_total;
  logic [IDX_W-1:0] zone_base;
  logic             protect_system;

  always_ff @(posedge clk) begin
    if (rst) begin
      clu_total      <= CLU_TOTAL_RESET;
      zone_base      <= '0;
      protect_system <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CLU_TOTAL:      clu_total      <= CNT_W'(cfg_data);
        CFG_ZONE_BASE:      zone_base      <= IDX_W'(cfg_data);
        CFG_PROTECT_SYSTEM: protect_system <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective cluster limit: count clamped to the map size
  logic [CNT_W-1:0] limit;
  assign limit = (32'(clu_total) > 32'(MAX_CLUSTERS)) ? CNT_W'(MAX_CLUSTERS)
                                                      : clu_total;

  // sequencer state
  seq_state_t       state, state_next;
  logic [AW-1:0]    clr_addr, clr_addr_next;
  logic [IDX_W-1:0] idx_q, idx_q_next;
  logic             want, want_next;
  logic [IDX_W-1:0] word_q, word_q_next;
  logic [BIW-1:0]   bit_q, bit_q_next;
  logic [SW-1:0]    scan_w, scan_w_next;
  logic [BW-1:0]    scan_base, scan_base_next;
  logic             chk_valid, chk_valid_next;
  logic [BW-1:0]    chk_base, chk_base_next;
  rsp_word_t        res, res_next;
  logic             rsp_valid;
  rsp_word_t        rsp_word;
  logic             rsp_load;

  // map memory ports
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [MW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [MW-1:0] mem_rdata;

  cba_map_ram #(
    .DEPTH  (DEPTH),
    .WIDTH  (MW),
    .ADDR_W (AW)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // index splitter for set requests: cluster -> map word, bit
  logic             div_start;
  logic             div_done;
  logic [IDX_W-1:0] div_q;
  logic [BIW-1:0]   div_r;

  cba_divider #(
    .NUM_W (IDX_W),
    .REM_W (BIW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (idx_q),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  function automatic logic [BIW-1:0] lowest_one(input logic [MW-1:0] v);
    logic [BIW-1:0] pos;
    pos = '0;
    for (int i = MW - 1; i >= 0; i--) begin
      if (v[i]) begin
        pos = BIW'(i);
      end
    end
    return pos;
  endfunction

  logic [MW-1:0]  free_bits;
  logic [BIW-1:0] low_b;
  logic [BW-1:0]  cand;
  logic           cand_ok;
  logic           issue_ok;
  logic           pre_refuse;

  assign free_bits = ~mem_rdata;
  assign low_b     = lowest_one(free_bits);
  assign cand      = chk_base + BW'(low_b);
  assign cand_ok   = 32'(cand) < 32'(limit);
  assign issue_ok  = (32'(scan_w) < 32'(DEPTH)) && (32'(scan_base) < 32'(limit));

  assign pre_refuse = (32'(req.payload.clu_index) >= 32'(limit)) ||
                      (protect_system && (req.payload.clu_index < zone_base));

  assign req.ready = (state == ST_IDLE);
  assign div_start = (state == ST_DIV) && !div_done && (word_q == '1) && (bit_q == '0);

  always_comb begin
    state_next     = state;
    clr_addr_next  = clr_addr;
    idx_q_next     = idx_q;
    want_next      = want;
    word_q_next    = word_q;
    bit_q_next     = bit_q;
    scan_w_next    = scan_w;
    scan_base_next = scan_base;
    chk_valid_next = chk_valid;
    chk_base_next  = chk_base;
    res_next       = res;
    rsp_load       = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = word_q[AW-1:0];
    mem_wdata      = mem_rdata;
    mem_raddr      = word_q[AW-1:0];

    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req.valid) begin
          idx_q_next = req.payload.clu_index;
          want_next  = req.payload.mark_used;
          res_next   = '0;
          if (req.payload.req_type == REQ_FIND) begin
            scan_w_next    = '0;
            scan_base_next = '0;
            chk_valid_next = 1'b0;
            state_next     = ST_FIND;
          end else if (pre_refuse) begin
            res_next.refused = 1'b1;
            state_next       = ST_DONE;
          end else begin
            // marker value: first DIV cycle kicks the divider
            word_q_next = '1;
            bit_q_next  = '0;
            state_next  = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_start) begin
          word_q_next = '0;
        end
        if (div_done) begin
          word_q_next = div_q;
          bit_q_next  = div_r;
          if (32'(div_q) >= 32'(DEPTH)) begin
            res_next.refused = 1'b1;
            state_next       = ST_DONE;
          end else begin
            state_next = ST_SET_RD;
          end
        end
      end
      ST_SET_RD: begin
        state_next = ST_SET_CHK;
      end
      ST_SET_CHK: begin
        if (mem_rdata[bit_q] == want) begin
          res_next.refused = 1'b1;
        end else begin
          mem_we             = 1'b1;
          mem_wdata[bit_q]   = want;
        end
        state_next = ST_DONE;
      end
      ST_FIND: begin
        mem_raddr = scan_w[AW-1:0];
        if (chk_valid && (free_bits != '0)) begin
          res_next.free_found = cand_ok;
          res_next.free_index = cand_ok ? IDX_W'(cand) : '0;
          state_next          = ST_DONE;
        end else if (issue_ok) begin
          chk_valid_next = 1'b1;
          chk_base_next  = scan_base;
          scan_w_next    = scan_w + SW'(1);
          scan_base_next = scan_base + BW'(MAP_WORD_BITS);
        end else if (chk_valid) begin
          chk_valid_next = 1'b0;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!rsp_valid || rsp.ready) begin
          rsp_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      chk_valid <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      chk_valid <= chk_valid_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_q     <= idx_q_next;
    want      <= want_next;
    word_q    <= word_q_next;
    bit_q     <= bit_q_next;
    scan_w    <= scan_w_next;
    scan_base <= scan_base_next;
    chk_base  <= chk_base_next;
    res       <= res_next;
    if (rsp_load) begin
      rsp_word <= res;
    end
  end

  assign rsp.valid   = rsp_valid;
  assign rsp.payload = rsp_word;

`ifndef SYNTHESIS
  a_no_rsp_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !rsp_valid)
    else $error("response during clearing pass");

  a_set_writes_asked: assert property (@(posedge clk) disable iff (rst)
    mem_we && state == ST_SET_CHK |-> mem_wdata[bit_q] == want && mem_rdata[bit_q] != want)
    else $error("map write does not flip the asked bit");

  a_found_below_limit: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_word.free_found |-> 32'(rsp_word.free_index) < 32'(limit))
    else $error("free index at or past cluster limit");

  a_fields_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_word.refused && rsp_word.free_found))
    else $error("refused and found both set");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside a set request");
`endif

endmodule

/* rtl/cba_map_ram.sv */
module cba_map_ram #(
  parameter int DEPTH  = 2048,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 11
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/cba_divider.sv */
module cba_divider #(
  parameter int NUM_W = 16,
  parameter int REM_W = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  output logic             done,
  output logic [NUM_W-1:0] quotient,
  output logic [REM_W-1:0] remainder
);

  // divisor is 2**REM_W: quotient is a shift, remainder a mask; result registered, ready in the cycle after start
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend >> REM_W;
      remainder <= dividend[REM_W-1:0];
    end
  end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import cba_pkg::*;

  // Geometry of the map, same as the block's default parameters.
  localparam int MAP_CLUSTERS = 65536;
  localparam int WORD_BITS    = 32;
  localparam int MAP_WORDS    = MAP_CLUSTERS / WORD_BITS;

  // Register index with no register behind it; a write there must be dropped.
  localparam logic [CFG_ADDR_W-1:0] CFG_NO_REG = 2'd3;

  // Largest legal field values.
  localparam logic [IDX_W-1:0]      IDX_MAX   = 16'hFFFF;
  localparam logic [CFG_DATA_W-1:0] COUNT_MAX = 17'h1FFFF;

  // Watchdog bound for the whole run: the clear pass, ~1000 words with stalls
  // and one long receiver hold, with ample margin.
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cba_word_if #(.payload_t(req_word_t)) req_if ();
  cba_word_if #(.payload_t(rsp_word_t)) rsp_if ();

  cluster_bitmap_allocator_top dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_if),
    .rsp       (rsp_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow of the block: used bit per cluster plus the three registers.
  // ---------------------------------------------------------------------------
  logic [WORD_BITS-1:0] used_words [MAP_WORDS];
  logic [CNT_W-1:0]     vol_clusters;
  logic [IDX_W-1:0]     zone_start;
  logic                 guard_system;

  rsp_word_t pending_rsp [$];   // outcomes of accepted requests, oldest first
  int errors = 0;
  int cycle_count = 0;

  // Idle odds in percent per cycle, and the receiver's long hold-off.
  int src_idle_pct;
  int snk_idle_pct;
  int hold_left = 0;

  // Outcome of one request; applies a successful set to the shadow map.
  function automatic rsp_word_t alloc_outcome(req_word_t w);
    rsp_word_t r;
    int unsigned span;
    int unsigned c;
    r = '0;
    // a count past the map size acts as the map size
    span = (vol_clusters > MAP_CLUSTERS) ? MAP_CLUSTERS : vol_clusters;
    if (w.req_type == REQ_SET) begin
      if (w.clu_index >= span || (guard_system && w.clu_index < zone_start)) begin
        r.refused = 1'b1;
      end else if (used_words[w.clu_index / WORD_BITS][w.clu_index % WORD_BITS]
                   == w.mark_used) begin
        r.refused = 1'b1;   // already in the asked state
      end else begin
        used_words[w.clu_index / WORD_BITS][w.clu_index % WORD_BITS] = w.mark_used;
      end
    end else begin
      // lowest free cluster below the count; protection plays no part here
      for (c = 0; c < span; c++) begin
        if (!used_words[c / WORD_BITS][c % WORD_BITS]) begin
          r.free_found = 1'b1;
          r.free_index = IDX_W'(c);
          break;
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving: everything changes at the falling edge.
  // ---------------------------------------------------------------------------

  // Offers one request word, with random gaps (junk payload while idle), and
  // records its outcome once taken. valid is left high for a following word.
  task automatic send_req(input logic op, input logic [IDX_W-1:0] idx, input logic mark);
    req_word_t w;
    w.req_type  = op;
    w.clu_index = idx;
    w.mark_used = mark;
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
      req_if.valid   <= 1'b0;
      req_if.payload <= req_word_t'($urandom);
    end
    @(negedge clk);
    req_if.valid   <= 1'b1;
    req_if.payload <= w;
    do @(posedge clk); while (!req_if.ready);
    pending_rsp.push_back(alloc_outcome(w));
  endtask

  // Stop offering and wait until every outstanding response is back.
  task automatic drain();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  // One register write; only called with the block idle.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_CLU_TOTAL:      vol_clusters = val[CNT_W-1:0];
      CFG_ZONE_BASE:      zone_start   = val[IDX_W-1:0];
      CFG_PROTECT_SYSTEM: guard_system = val[0];
      default: ;
    endcase
  endtask

  task automatic set_volume(input logic [CFG_DATA_W-1:0] cnt, input logic [IDX_W-1:0] zs,
                            input logic prot);
    drain();
    write_reg(CFG_CLU_TOTAL, cnt);
    write_reg(CFG_ZONE_BASE, CFG_DATA_W'(zs));
    write_reg(CFG_PROTECT_SYSTEM, CFG_DATA_W'(prot));
  endtask

  // Random request: mostly sets and finds around the live cluster range so the
  // map fills up; some fully random indexes and some at the data zone edge.
  task automatic send_random_req();
    int unsigned span;
    int unsigned pick;
    logic [IDX_W-1:0] idx;
    span = (vol_clusters > 300) ? 300 : vol_clusters + 8;
    pick = $urandom_range(99);
    if (pick < 20)
      idx = IDX_W'($urandom);
    else if (pick < 30)
      idx = IDX_W'(zone_start - 1 + $urandom_range(2));
    else
      idx = IDX_W'($urandom_range(span - 1));
    if ($urandom_range(99) < 35)
      send_req(REQ_FIND, idx, 1'($urandom));
    else
      send_req(REQ_SET, idx, $urandom_range(99) < 65);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random ready, or held low for a counted stretch.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left > 0) begin
      rsp_if.ready <= 1'b0;
      hold_left--;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Response checker: each taken word against the oldest outcome.
  always @(posedge clk) begin : check_rsp
    rsp_word_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected response word, actual %p", $time, rsp_if.payload);
        errors++;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_if.payload.refused !== want.refused) begin
          $display("%0t: refused mismatch, expected %0b, actual %0b",
                   $time, want.refused, rsp_if.payload.refused);
          errors++;
        end
        if (rsp_if.payload.free_found !== want.free_found) begin
          $display("%0t: free_found mismatch, expected %0b, actual %0b",
                   $time, want.free_found, rsp_if.payload.free_found);
          errors++;
        end
        if (rsp_if.payload.free_index !== want.free_index) begin
          $display("%0t: free_index mismatch, expected %0d, actual %0d",
                   $time, want.free_index, rsp_if.payload.free_index);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles", $time, cycle_count);
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Map is clear after reset, so cluster 0 is free at the reset count.
  task automatic test_reset_find();
    send_req(REQ_FIND, '0, 1'b0);
  endtask

  // Mark / unmark, repeated marks refused, both index extremes.
  task automatic test_set_clear();
    send_req(REQ_SET, '0, 1'b1);
    send_req(REQ_SET, '0, 1'b1);        // unchanged -> refused
    send_req(REQ_FIND, '0, 1'b0);       // now cluster 1
    send_req(REQ_SET, '0, 1'b0);
    send_req(REQ_SET, '0, 1'b0);        // unchanged -> refused
    send_req(REQ_SET, IDX_MAX, 1'b1);
    send_req(REQ_SET, IDX_MAX, 1'b0);
  endtask

  // Zero count, oversized count, and a tiny volume filled to the brim.
  task automatic test_count_limits();
    set_volume('0, '0, 1'b0);
    send_req(REQ_SET, 16'd5, 1'b1);     // nothing is in range
    send_req(REQ_FIND, '0, 1'b0);       // not found, index 0
    set_volume(COUNT_MAX, '0, 1'b0);    // clamps to the map size
    send_req(REQ_SET, IDX_MAX, 1'b1);
    send_req(REQ_SET, IDX_MAX, 1'b0);
    set_volume(17'd4, '0, 1'b0);
    send_req(REQ_SET, 16'd0, 1'b1);
    send_req(REQ_SET, 16'd1, 1'b1);
    send_req(REQ_SET, 16'd2, 1'b1);
    send_req(REQ_SET, 16'd3, 1'b1);
    send_req(REQ_FIND, '0, 1'b0);       // volume full
    send_req(REQ_SET, 16'd4, 1'b1);     // just past the count
  endtask

  // Protection edge, protection off, dead register index, top zone start.
  task automatic test_protection();
    set_volume(17'd64, 16'd10, 1'b1);
    send_req(REQ_SET, 16'd9, 1'b1);     // below the zone -> refused
    send_req(REQ_SET, 16'd10, 1'b1);    // first zone cluster is fair game
    send_req(REQ_FIND, '0, 1'b0);       // find ignores protection
    drain();
    write_reg(CFG_PROTECT_SYSTEM, '0);
    send_req(REQ_SET, 16'd9, 1'b1);
    drain();
    write_reg(CFG_NO_REG, COUNT_MAX);   // must not touch any register
    send_req(REQ_SET, 16'd9, 1'b0);
    set_volume(CLU_TOTAL_RESET, IDX_MAX, 1'b1);
    send_req(REQ_SET, IDX_MAX - 1, 1'b1);
    send_req(REQ_SET, IDX_MAX, 1'b1);
  endtask

  // Receiver stalls for a long stretch while the sender keeps pushing, so the
  // output register fills and the request side backs up.
  task automatic test_backpressure();
    int k;
    set_volume(17'd200, 16'd20, 1'b0);
    src_idle_pct = 0;
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    for (k = 0; k < 16; k++)
      send_random_req();
    drain();
  endtask

  // Three idle profiles, several volume settings each, random traffic.
  task automatic test_random_traffic();
    int ph;
    int st;
    int k;
    logic [CFG_DATA_W-1:0] cnt;
    logic [IDX_W-1:0] zs;
    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin src_idle_pct = 11; snk_idle_pct = 73; end
        1: begin src_idle_pct = 73; snk_idle_pct = 11; end
        default: begin src_idle_pct = 0; snk_idle_pct = 0; end
      endcase
      for (st = 0; st < 5; st++) begin
        case ($urandom_range(9))
          0: cnt = '0;
          1: cnt = CLU_TOTAL_RESET;
          2: cnt = CFG_DATA_W'($urandom_range(65537, 131071));
          3, 4, 5: cnt = CFG_DATA_W'($urandom_range(1, 40));
          default: cnt = CFG_DATA_W'($urandom_range(41, 300));
        endcase
        zs = ($urandom_range(3) == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(64));
        set_volume(cnt, zs, 1'($urandom));
        if ($urandom_range(4) == 0)
          write_reg(CFG_NO_REG, CFG_DATA_W'($urandom));
        for (k = 0; k < 62; k++)
          send_random_req();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst            = 1'b1;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    rsp_if.ready   = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    src_idle_pct   = 11;
    snk_idle_pct   = 73;
    foreach (used_words[i]) used_words[i] = '0;
    vol_clusters   = CLU_TOTAL_RESET;
    zone_start     = '0;
    guard_system   = 1'b0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // block runs its clearing pass first; send_req just waits on ready
    test_reset_find();
    test_set_clear();
    test_count_limits();
    test_protection();
    test_backpressure();
    test_random_traffic();

    drain();
    repeat (40) @(posedge clk);   // catch any stray word after the last one
    if (errors == 0 && pending_rsp.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
